@@ rtl/modular_arithmetic_unit_core_macros.svh @@
// Assertion macros shared by the modular arithmetic unit RTL.
// No dependencies; included by the files that carry assertions.
`ifndef MODULAR_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define MAU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("modular arithmetic unit assertion failed");
`define MAU_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("modular arithmetic unit reset assertion failed");
`else
`define MAU_ASSERT(lbl, clk, rstn, prop)
`define MAU_ASSERT_RST(lbl, clk, prop)
`endif
`endif

@@ rtl/mau_pkg.sv @@
// Types and constants of the modular arithmetic unit.
// No dependencies; used by every module of the block.
`default_nettype none
package mau_pkg;
  localparam int unsigned OP_W = 31;
  localparam int unsigned EXP_W = 64;
  localparam logic [OP_W-1:0] MOD_RESET = 31'd1000000007;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_NEG = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_INV = 3'd5,
    OP_POW = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    MS_RED_A,
    MS_RED_B,
    MS_A_B,
    MS_A_RES,
    MS_Y_BASE,
    MS_BASE_BASE
  } mul_sel_e;

  typedef enum logic [1:0] {
    IS_A,
    IS_B,
    IS_Y
  } inv_sel_e;

  typedef struct packed {
    logic     load;
    logic     zero_res;
    logic     alu;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     inv_start;
    inv_sel_e inv_sel;
    logic     pow_init;
    logic     exp_shift;
    logic     copy_y;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic       mod_small;
    logic [2:0] opcode;
    logic       mul_busy;
    logic       mul_done;
    logic       inv_done;
    logic       exp_zero;
    logic       exp_lsb;
    logic       exp_neg;
  } sts_t;
endpackage
`default_nettype wire

@@ rtl/mau_mulmod.sv @@
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
// Depends on mau_pkg.
`default_nettype none
module mau_mulmod #(
  parameter int unsigned MW = 31
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [MW-1:0]             x_i,
  input  wire logic [mau_pkg::OP_W-1:0]  y_i,
  input  wire logic [MW-1:0]             m_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [MW-1:0]                  res_o
);
  import mau_pkg::*;

  localparam int unsigned CW = $clog2(OP_W);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [MW-1:0] x_q;
  logic [MW-1:0] acc_q;
  logic [OP_W-1:0] y_q;
  logic [MW:0]   dbl;
  logic [MW:0]   dbl_r;
  logic [MW:0]   sum;
  logic [MW:0]   sum_r;

  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    sum   = dbl_r + (y_q[OP_W-1] ? {1'b0, x_q} : '0);
    sum_r = (sum >= {1'b0, m_i}) ? sum - {1'b0, m_i} : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(OP_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= sum_r[MW-1:0];
      y_q   <= {y_q[OP_W-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = acc_q;
endmodule
`default_nettype wire

@@ rtl/mau_euclid.sv @@
// Extended Euclid inverse unit; each quotient is found by restoring division,
// one quotient bit per cycle. Depends on mau_pkg.
`default_nettype none
module mau_euclid #(
  parameter int unsigned MW = 31
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [MW-1:0] x_i,
  input  wire logic [MW-1:0] m_i,
  output logic               done_o,
  output logic [MW-1:0]      res_o,
  output logic               bad_o
);
  import mau_pkg::*;

  localparam int unsigned SW = 2 * MW + 2;
  localparam int unsigned IW = $clog2(MW);

  typedef enum logic [1:0] {
    E_IDLE,
    E_CHECK,
    E_DIV,
    E_FIX
  } euc_state_e;

  euc_state_e state_q;
  logic done_q;
  logic [MW-1:0] r0_q;
  logic [MW-1:0] r1_q;
  logic [MW-1:0] rem_q;
  logic signed [SW-1:0] s0_q;
  logic signed [SW-1:0] s1_q;
  logic signed [SW-1:0] ns_q;
  logic [IW-1:0] idx_q;
  logic [MW-1:0] res_q;
  logic bad_q;

  logic [2*MW-1:0] shifted;
  logic take;
  logic [MW-1:0] rem_nx;
  logic signed [SW-1:0] ns_nx;
  logic signed [SW-1:0] m_ext;
  logic signed [SW-1:0] fixed;

  always_comb begin
    shifted = {{MW{1'b0}}, r1_q} << idx_q;
    take    = shifted <= {{MW{1'b0}}, rem_q};
    rem_nx  = take ? rem_q - shifted[MW-1:0] : rem_q;
    ns_nx   = take ? ns_q - (s1_q <<< idx_q) : ns_q;
    m_ext   = $signed({{(SW-MW){1'b0}}, m_i});
    if (s0_q[SW-1]) begin
      fixed = s0_q + m_ext;
    end else if (s0_q >= m_ext) begin
      fixed = s0_q - m_ext;
    end else begin
      fixed = s0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        E_IDLE: begin
          if (start_i) begin
            state_q <= E_CHECK;
          end
        end
        E_CHECK: begin
          state_q <= (r1_q == '0) ? E_FIX : E_DIV;
        end
        E_DIV: begin
          if (idx_q == '0) begin
            state_q <= E_CHECK;
          end
        end
        E_FIX: begin
          state_q <= E_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      E_IDLE: begin
        if (start_i) begin
          r0_q <= x_i;
          r1_q <= m_i;
          s0_q <= SW'(1);
          s1_q <= '0;
        end
      end
      E_CHECK: begin
        rem_q <= r0_q;
        ns_q  <= s0_q;
        idx_q <= IW'(MW - 1);
      end
      E_DIV: begin
        rem_q <= rem_nx;
        ns_q  <= ns_nx;
        idx_q <= idx_q - 1'b1;
        if (idx_q == '0) begin
          r0_q <= r1_q;
          r1_q <= rem_nx;
          s0_q <= s1_q;
          s1_q <= ns_nx;
        end
      end
      E_FIX: begin
        res_q <= fixed[MW-1:0];
        bad_q <= (r0_q != MW'(1));
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign bad_o  = bad_q;
endmodule
`default_nettype wire

@@ rtl/mau_dp.sv @@
// Datapath: modulus register, operand and power registers, add/sub/neg logic,
// output register. Depends on mau_pkg, mau_mulmod and mau_euclid.
`default_nettype none
module mau_dp #(
  parameter int unsigned MW = 31
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mau_pkg::cmd_t                 cmd_i,
  output mau_pkg::sts_t                      sts_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mau_pkg::OP_W-1:0]      cfg_data_i,
  input  wire logic [2:0]                    opcode_i,
  input  wire logic [mau_pkg::OP_W-1:0]      operand_a_i,
  input  wire logic [mau_pkg::OP_W-1:0]      operand_b_i,
  input  wire logic signed [mau_pkg::EXP_W-1:0] exponent_i,
  output logic [mau_pkg::OP_W-1:0]           result_o,
  output logic                               status_o
);
  import mau_pkg::*;

  logic [MW-1:0]    mod_q;
  logic [2:0]       op_q;
  logic [OP_W-1:0]  ra_q;
  logic [OP_W-1:0]  rb_q;
  logic [MW-1:0]    a_q;
  logic [MW-1:0]    b_q;
  logic [MW-1:0]    y_q;
  logic [MW-1:0]    base_q;
  logic [MW-1:0]    res_q;
  logic             bad_q;
  logic [EXP_W-1:0] exp_q;
  logic             neg_q;
  mul_sel_e         msel_q;
  logic [MW-1:0]    out_res_q;
  logic             out_bad_q;

  logic [EXP_W-1:0] e_raw;
  logic [EXP_W-1:0] e_mag;
  logic [MW-1:0]    mx;
  logic [OP_W-1:0]  my;
  logic [MW-1:0]    ix;
  logic             mul_busy;
  logic             mul_done;
  logic [MW-1:0]    mul_res;
  logic             inv_done;
  logic [MW-1:0]    inv_res;
  logic             inv_bad;
  logic [MW:0]      add_s;
  logic [MW:0]      add_r;
  logic [MW-1:0]    sub_r;
  logic [MW-1:0]    neg_r;
  logic [MW-1:0]    alu_r;

  always_comb begin
    e_raw = exponent_i;
    e_mag = e_raw[EXP_W-1] ? (~e_raw + 1'b1) : e_raw;
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_RED_A: begin
        mx = MW'(1);
        my = ra_q;
      end
      MS_RED_B: begin
        mx = MW'(1);
        my = rb_q;
      end
      MS_A_B: begin
        mx = a_q;
        my = OP_W'(b_q);
      end
      MS_A_RES: begin
        mx = a_q;
        my = OP_W'(res_q);
      end
      MS_Y_BASE: begin
        mx = y_q;
        my = OP_W'(base_q);
      end
      MS_BASE_BASE: begin
        mx = base_q;
        my = OP_W'(base_q);
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end

  always_comb begin
    unique case (cmd_i.inv_sel)
      IS_A:    ix = a_q;
      IS_B:    ix = b_q;
      IS_Y:    ix = y_q;
      default: ix = '0;
    endcase
  end

  always_comb begin
    add_s = {1'b0, a_q} + {1'b0, b_q};
    add_r = (add_s >= {1'b0, mod_q}) ? add_s - {1'b0, mod_q} : add_s;
    sub_r = (a_q >= b_q) ? a_q - b_q : a_q + (mod_q - b_q);
    neg_r = (a_q == '0) ? '0 : mod_q - a_q;
    unique case (op_q)
      OP_ADD:  alu_r = add_r[MW-1:0];
      OP_SUB:  alu_r = sub_r;
      default: alu_r = neg_r;
    endcase
  end

  mau_mulmod #(
    .MW(MW)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .x_i    (mx),
    .y_i    (my),
    .m_i    (mod_q),
    .busy_o (mul_busy),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  mau_euclid #(
    .MW(MW)
  ) u_euclid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.inv_start),
    .x_i    (ix),
    .m_i    (mod_q),
    .done_o (inv_done),
    .res_o  (inv_res),
    .bad_o  (inv_bad)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MOD_RESET[MW-1:0];
    end else if (cfg_we_i) begin
      mod_q <= cfg_data_i[MW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      ra_q  <= operand_a_i;
      rb_q  <= operand_b_i;
      exp_q <= e_mag;
      neg_q <= e_raw[EXP_W-1];
      bad_q <= 1'b0;
    end
    if (cmd_i.mul_start) begin
      msel_q <= cmd_i.mul_sel;
    end
    if (cmd_i.zero_res) begin
      res_q <= '0;
    end
    if (cmd_i.alu) begin
      res_q <= alu_r;
    end
    if (cmd_i.copy_y) begin
      res_q <= y_q;
    end
    if (cmd_i.pow_init) begin
      y_q    <= MW'(1);
      base_q <= a_q;
    end
    if (cmd_i.exp_shift) begin
      exp_q <= exp_q >> 1;
    end
    if (mul_done) begin
      unique case (msel_q)
        MS_RED_A:     a_q    <= mul_res;
        MS_RED_B:     b_q    <= mul_res;
        MS_Y_BASE:    y_q    <= mul_res;
        MS_BASE_BASE: base_q <= mul_res;
        default:      res_q  <= mul_res;
      endcase
    end
    if (inv_done) begin
      res_q <= inv_res;
      bad_q <= inv_bad;
    end
    if (cmd_i.out_load) begin
      out_res_q <= res_q;
      out_bad_q <= bad_q;
    end
  end

  always_comb begin
    sts_o.mod_small = (mod_q < MW'(2));
    sts_o.opcode    = op_q;
    sts_o.mul_busy  = mul_busy;
    sts_o.mul_done  = mul_done;
    sts_o.inv_done  = inv_done;
    sts_o.exp_zero  = (exp_q == '0);
    sts_o.exp_lsb   = exp_q[0];
    sts_o.exp_neg   = neg_q;
  end

  assign result_o = OP_W'(out_res_q);
  assign status_o = out_bad_q;
endmodule
`default_nettype wire

@@ rtl/mau_ctrl.sv @@
// Controller state machine: sequences operand reduction, the operation and
// the output hand-off. Depends on mau_pkg and the assertion macro header.
`default_nettype none
`include "modular_arithmetic_unit_core_macros.svh"
module mau_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire mau_pkg::sts_t sts_i,
  output mau_pkg::cmd_t      cmd_o
);
  import mau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RED_A,
    S_RED_B,
    S_DISPATCH,
    S_DIV_INV,
    S_DIV_MUL,
    S_MUL,
    S_INV,
    S_POW_CHK,
    S_POW_Y,
    S_POW_B,
    S_DONE
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.mod_small || (sts_i.opcode > OP_POW)) begin
          cmd_o.zero_res = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MS_RED_A;
          state_d         = S_RED_A;
        end
      end
      S_RED_A: begin
        if (sts_i.mul_done) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MS_RED_B;
          state_d         = S_RED_B;
        end
      end
      S_RED_B: begin
        if (sts_i.mul_done) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.opcode)
          OP_ADD, OP_SUB, OP_NEG: begin
            cmd_o.alu = 1'b1;
            state_d   = S_DONE;
          end
          OP_MUL: begin
            cmd_o.mul_start = 1'b1;
            cmd_o.mul_sel   = MS_A_B;
            state_d         = S_MUL;
          end
          OP_DIV: begin
            cmd_o.inv_start = 1'b1;
            cmd_o.inv_sel   = IS_B;
            state_d         = S_DIV_INV;
          end
          OP_INV: begin
            cmd_o.inv_start = 1'b1;
            cmd_o.inv_sel   = IS_A;
            state_d         = S_INV;
          end
          OP_POW: begin
            cmd_o.pow_init = 1'b1;
            state_d        = S_POW_CHK;
          end
          default: begin
            cmd_o.zero_res = 1'b1;
            state_d        = S_DONE;
          end
        endcase
      end
      S_DIV_INV: begin
        if (sts_i.inv_done) begin
          state_d = S_DIV_MUL;
        end
      end
      S_DIV_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MS_A_RES;
        state_d         = S_MUL;
      end
      S_MUL: begin
        if (sts_i.mul_done) begin
          state_d = S_DONE;
        end
      end
      S_INV: begin
        if (sts_i.inv_done) begin
          state_d = S_DONE;
        end
      end
      S_POW_CHK: begin
        if (sts_i.exp_zero) begin
          if (sts_i.exp_neg) begin
            cmd_o.inv_start = 1'b1;
            cmd_o.inv_sel   = IS_Y;
            state_d         = S_INV;
          end else begin
            cmd_o.copy_y = 1'b1;
            state_d      = S_DONE;
          end
        end else if (sts_i.exp_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MS_Y_BASE;
          state_d         = S_POW_Y;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MS_BASE_BASE;
          state_d         = S_POW_B;
        end
      end
      S_POW_Y: begin
        if (sts_i.mul_done) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MS_BASE_BASE;
          state_d         = S_POW_B;
        end
      end
      S_POW_B: begin
        if (sts_i.mul_done) begin
          cmd_o.exp_shift = 1'b1;
          state_d         = S_POW_CHK;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `MAU_ASSERT(a_accept_then_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `MAU_ASSERT(a_mul_start_idle, clk_i, rst_ni, cmd_o.mul_start |-> !sts_i.mul_busy)
  `MAU_ASSERT(a_out_from_load, clk_i, rst_ni, $rose(out_valid_o) |-> $past(cmd_o.out_load))
  `MAU_ASSERT_RST(a_reset_no_out, clk_i, !rst_ni |=> !out_valid_o)
endmodule
`default_nettype wire

@@ rtl/modular_arithmetic_unit_core.sv @@
// Modular arithmetic unit: add, sub, neg, mul, div, inverse and signed power
// over a programmable modulus. Depends on mau_pkg, mau_ctrl and mau_dp.
//
// Input words (opcode, two residues, signed exponent) are taken on in_valid_i
// while in_stall_o is low; each word gives one output word (result, status)
// on out_valid_o, held until out_stall_i is low. One word is in work at a
// time; a finished word may wait in the output register while the next one
// is accepted and computed.
// Latency is set by the bit-serial modular multiplier and the Euclid unit.
// Unless the modulus is below 2 or the opcode is invalid, both operands are
// first reduced by one product each; mul then adds one product; inverse adds
// the Euclid rounds and div one product more; pow adds a squaring per exponent
// bit and a product per set bit, plus an inverse for a negative exponent.
// Reset clears the control, the output valid and sets the modulus to
// 1000000007; the user must write the modulus register with cfg_we_i only
// while idle, and the block itself does not enforce it.
// A stalled output word blocks the next result from leaving the controller.
`default_nettype none
module modular_arithmetic_unit_core #(
  parameter int unsigned MOD_WIDTH = 31
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mau_pkg::OP_W-1:0]         cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [2:0]                       opcode_i,
  input  wire logic [mau_pkg::OP_W-1:0]         operand_a_i,
  input  wire logic [mau_pkg::OP_W-1:0]         operand_b_i,
  input  wire logic signed [mau_pkg::EXP_W-1:0] exponent_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [mau_pkg::OP_W-1:0]              result_o,
  output logic                                  status_o
);
  import mau_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mau_dp #(
    .MW(MOD_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .opcode_i   (opcode_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .exponent_i (exponent_i),
    .result_o   (result_o),
    .status_o   (status_o)
  );
endmodule
`default_nettype wire

@@ test/tb_modular_arithmetic_unit_core.sv @@
// Self-checking testbench for the modular arithmetic unit core.
// Drives directed and random words over several moduli and checks every output word
// against a literal or a local predictor. Depends on mau_pkg and modular_arithmetic_unit_core.
`timescale 1ns / 1ps
`default_nettype none
module tb_modular_arithmetic_unit_core;
  import mau_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20000000;
  localparam int unsigned RAND_PER_PHASE = 190;

  typedef struct packed {
    logic [OP_W-1:0] res;
    logic            st;
  } outcome_t;

  typedef struct {
    logic [2:0]        op;
    logic [OP_W-1:0]   a;
    logic [OP_W-1:0]   b;
    logic [EXP_W-1:0]  e;
    bit                fixed;
    logic [OP_W-1:0]   res;
    logic              st;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [OP_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] opcode_i = '0;
  logic [OP_W-1:0] operand_a_i = '0;
  logic [OP_W-1:0] operand_b_i = '0;
  logic signed [EXP_W-1:0] exponent_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [OP_W-1:0] result_o;
  logic status_o;

  outcome_t pending_results[$];
  logic [63:0] cur_modulus = 64'(MOD_RESET);
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit quiet = 1'b0;
  bit hold = 1'b0;

  modular_arithmetic_unit_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .opcode_i(opcode_i),
    .operand_a_i(operand_a_i), .operand_b_i(operand_b_i), .exponent_i(exponent_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .result_o(result_o),
    .status_o(status_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [63:0] euclid_inverse(logic [63:0] x, logic [63:0] m,
                                                 output logic bad);
    longint r0, r1, s0, s1, q, nr, ns;
    r0 = longint'(x);
    r1 = longint'(m);
    s0 = 1;
    s1 = 0;
    while (r1 != 0) begin
      q = r0 / r1;
      nr = r0 - q * r1;
      ns = s0 - q * s1;
      r0 = r1;
      r1 = nr;
      s0 = s1;
      s1 = ns;
    end
    bad = (r0 != 1);
    s0 = s0 % longint'(m);
    if (s0 < 0) s0 = s0 + longint'(m);
    return 64'(s0);
  endfunction

  function automatic outcome_t mau_predict(logic [2:0] op, logic [OP_W-1:0] a_in,
                                           logic [OP_W-1:0] b_in, logic [EXP_W-1:0] e);
    logic [63:0] m, a, b, r, y, bs, mag;
    logic bad;
    outcome_t o;
    m = cur_modulus;
    r = 0;
    bad = 1'b0;
    if (m >= 2) begin
      a = 64'(a_in) % m;
      b = 64'(b_in) % m;
      mag = e[63] ? (~e + 64'd1) : e;
      case (op)
        OP_ADD: r = (a + b) % m;
        OP_SUB: r = (a + m - b) % m;
        OP_NEG: r = (m - a) % m;
        OP_MUL: r = (a * b) % m;
        OP_DIV: r = (a * euclid_inverse(b, m, bad)) % m;
        OP_INV: r = euclid_inverse(a, m, bad);
        OP_POW: begin
          y = 64'd1 % m;
          bs = a;
          while (mag != 0) begin
            if (mag[0]) y = (y * bs) % m;
            bs = (bs * bs) % m;
            mag = mag >> 1;
          end
          r = e[63] ? euclid_inverse(y, m, bad) : y;
        end
        default: r = 0;
      endcase
    end
    o.res = r[OP_W-1:0];
    o.st = bad;
    return o;
  endfunction

  task automatic send_word(logic [2:0] op, logic [OP_W-1:0] a, logic [OP_W-1:0] b,
                           logic [EXP_W-1:0] e, bit fixed, outcome_t lit);
    int unsigned gap;
    opcode_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    exponent_i <= e;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(fixed ? lit : mau_predict(op, a, b, e));
    n_sent++;
    gap = 0;
    if (!quiet) begin
      case ($urandom_range(0, 99)) inside
        [0:49]: gap = 0;
        [50:96]: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(10, 80);
      endcase
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_modulus(logic [OP_W-1:0] v);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_modulus = 64'(v);
  endtask

  function automatic logic [OP_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      2: return OP_W'(cur_modulus - 1);
      3: return OP_W'(cur_modulus);
      4, 5: return OP_W'($urandom_range(0, 40));
      default: return OP_W'($urandom);
    endcase
  endfunction

  function automatic logic [EXP_W-1:0] pick_exponent();
    logic [EXP_W-1:0] e;
    case ($urandom_range(0, 19))
      0: e = {1'b1, 63'd0};
      1: e = {1'b0, {63{1'b1}}};
      2, 3: e = {$urandom, $urandom};
      default: e = 64'($urandom_range(0, 300));
    endcase
    if ($urandom_range(0, 1) && e[63] == 1'b0 && e != {1'b0, {63{1'b1}}}) e = -e;
    return e;
  endfunction

  // Receiver: checks each accepted word, then picks the stall for the next edge.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word result=%0d status=%0d", $time, result_o, status_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result_o !== want.res) begin
          $display("%0t: result expected %0d actual %0d", $time, want.res, result_o);
          errors++;
        end
        if (status_o !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status_o);
          errors++;
        end
      end
    end
    if (hold) begin
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:54]: stall_left = 0;
        [55:96]: stall_left = $urandom_range(1, 3);
        default: stall_left = $urandom_range(10, 120);
      endcase
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Long hold-off of the receiver while the sender keeps offering words.
  initial begin
    wait (n_sent == 300);
    @(posedge clk_i);
    hold = 1'b1;
    repeat (6000) @(posedge clk_i);
    hold = 1'b0;
  end

  initial begin
    row_t rows[$];
    logic [OP_W-1:0] moduli[6];
    outcome_t lit;
    logic [OP_W-1:0] mmax;
    mmax = '1;
    rows = '{
      '{3'(OP_ADD), 0, 0, 0, 1, 0, 0},
      '{3'(OP_ADD), 1, 2, 0, 1, 3, 0},
      '{3'(OP_ADD), mmax, mmax, 0, 0, 0, 0},
      '{3'(OP_SUB), 0, 1, 0, 1, 1000000006, 0},
      '{3'(OP_SUB), mmax, 0, 0, 0, 0, 0},
      '{3'(OP_NEG), 0, 5, 0, 1, 0, 0},
      '{3'(OP_NEG), 1, 0, 0, 1, 1000000006, 0},
      '{3'(OP_MUL), 0, mmax, 0, 1, 0, 0},
      '{3'(OP_MUL), mmax, mmax, 0, 0, 0, 0},
      '{3'(OP_DIV), 5, 0, 0, 1, 0, 1},
      '{3'(OP_DIV), 7, 3, 0, 0, 0, 0},
      '{3'(OP_INV), 0, 0, 0, 1, 0, 1},
      '{3'(OP_INV), 1, 0, 0, 1, 1, 0},
      '{3'(OP_INV), 1000000006, 0, 0, 1, 1000000006, 0},
      '{3'(OP_INV), 1000000007, 0, 0, 1, 0, 1},
      '{3'(OP_POW), 12345, 0, 0, 1, 1, 0},
      '{3'(OP_POW), 0, 0, 0, 1, 1, 0},
      '{3'(OP_POW), 0, 0, '1, 1, 0, 1},
      '{3'(OP_POW), 2, 0, {1'b1, 63'd0}, 0, 0, 0},
      '{3'(OP_POW), mmax, 0, {1'b0, {63{1'b1}}}, 0, 0, 0},
      '{3'(OP_POW), 3, 0, -64'sd5, 0, 0, 0},
      '{3'd7, mmax, mmax, '1, 1, 0, 0}
    };
    moduli = '{31'd2, 31'h7FFF_FFFF, 31'd1 << 30, 31'd12, 31'd1000000007, 31'd0};
    moduli[5] = 31'($urandom_range(3, 32'h7FFF_FFFF));
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      lit.res = rows[i].res;
      lit.st = rows[i].st;
      send_word(rows[i].op, rows[i].a, rows[i].b, rows[i].e, rows[i].fixed, lit);
    end
    foreach (moduli[p]) begin
      load_modulus(moduli[p]);
      quiet = (p == 4);
      repeat (RAND_PER_PHASE) begin
        send_word(3'($urandom_range(0, 7)), pick_operand(), pick_operand(),
                  pick_exponent(), 1'b0, '0);
      end
      quiet = 1'b0;
    end
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
